/* rtl/lobm_pkg.sv */
// shared types and constants of the order book matcher
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;

    typedef enum logic [1:0] {
        ST_ADDED    = 2'd0,
        ST_REJECTED = 2'd1,
        ST_TRADE    = 2'd2,
        ST_NO_CROSS = 2'd3
    } status_t;

    // which front order is used up by a trade
    typedef enum logic [1:0] {
        K_ASK_SMALLER,
        K_BID_SMALLER,
        K_EQUAL
    } kind_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WAIT,
        S_ADD_WR,
        S_ADD_LINK,
        S_M_RDHEAD,
        S_M_WAITHEAD,
        S_M_RDSLOT,
        S_M_WAITSLOT,
        S_M_DECIDE,
        S_M_POP_ASK,
        S_M_POP_BID,
        S_M_SCAN_ASK_RD,
        S_M_SCAN_ASK_CHK,
        S_M_SCAN_BID_RD,
        S_M_SCAN_BID_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        mode;
        logic        buy_not_sell;
        logic [9:0]  price;
        logic [31:0] quantity;
        logic [31:0] order_ident;
    } order_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] bid_ident;
        logic [31:0] ask_ident;
        logic [31:0] fill_quantity;
        logic        still_crossed;
    } result_t;

endpackage
`default_nettype wire

/* rtl/lobm_stream_if.sv */
// valid/ready channel carrying one payload beat
`timescale 1ns / 1ps
`default_nettype none
interface lobm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/lobm_ram.sv */
// generic single-port write, single-port registered read ram
`timescale 1ns / 1ps
`default_nettype none
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/limit_order_book_matcher.sv */
// top level of the price-time priority order book matcher
//
// Each input beat gives exactly one result beat, and one item is in the block at a time.
// After reset the block sweeps the level head memories, one level a cycle for both sides
// at once, and accepts no item until done. A rejected add or a step on an uncrossed book
// goes straight to the result; an add writes the new slot and the level's tail, sets the
// head of an empty level and otherwise links behind the level's old tail; a trade pops the
// ask front, the bid front or both when both fill, and the rescan after a level empties
// examines one price level at a time. The input is ready again in the cycle the result
// shows, and waits while an earlier result is still held.
// Heads and tails live in separate memories per side, links, idents and quantities in
// slot memories; the free-list head and never-used counter sit in flip-flops.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book_matcher #(
    parameter int MAX_PRICE_LEVEL = 1023,
    parameter int ORDER_SLOTS     = 1024
) (
    input wire logic clk,
    input wire logic rst_n,
    lobm_stream_if.sink   in_ch,
    lobm_stream_if.source out_ch
);
    localparam int LEVELS = MAX_PRICE_LEVEL + 1;
    localparam int LW     = $clog2(LEVELS);
    localparam int PW     = LW + 1;                 // price incl. no-ask mark
    localparam int SW     = $clog2(ORDER_SLOTS);
    localparam int HW     = SW + 1;                 // slot index incl. nil
    localparam logic [HW-1:0] NIL = HW'(ORDER_SLOTS);
    localparam logic [PW-1:0] NO_ASK = PW'(LEVELS);

    // ---------------- memories ----------------
    logic          bh_we, ah_we, bt_we, at_we, sn_we, si_we, sq_we;
    logic [LW-1:0] bh_wa, ah_wa, bt_wa, at_wa, bh_ra, ah_ra, bt_ra, at_ra;
    logic [HW-1:0] bh_wd, ah_wd, bh_rd, ah_rd, sn_wd, sn_rd;
    logic [SW-1:0] bt_wd, at_wd, bt_rd, at_rd;
    logic [SW-1:0] sn_wa, sn_ra, si_wa, si_ra, sq_wa, sq_ra;
    logic [31:0]   si_wd, si_rd, sq_wd, sq_rd;

    lobm_ram #(.WIDTH(HW), .DEPTH(LEVELS)) u_bid_head (
        .clk(clk), .we(bh_we), .waddr(bh_wa), .wdata(bh_wd), .raddr(bh_ra), .rdata(bh_rd));
    lobm_ram #(.WIDTH(HW), .DEPTH(LEVELS)) u_ask_head (
        .clk(clk), .we(ah_we), .waddr(ah_wa), .wdata(ah_wd), .raddr(ah_ra), .rdata(ah_rd));
    lobm_ram #(.WIDTH(SW), .DEPTH(LEVELS)) u_bid_tail (
        .clk(clk), .we(bt_we), .waddr(bt_wa), .wdata(bt_wd), .raddr(bt_ra), .rdata(bt_rd));
    lobm_ram #(.WIDTH(SW), .DEPTH(LEVELS)) u_ask_tail (
        .clk(clk), .we(at_we), .waddr(at_wa), .wdata(at_wd), .raddr(at_ra), .rdata(at_rd));
    lobm_ram #(.WIDTH(HW), .DEPTH(ORDER_SLOTS)) u_slot_next (
        .clk(clk), .we(sn_we), .waddr(sn_wa), .wdata(sn_wd), .raddr(sn_ra), .rdata(sn_rd));
    lobm_ram #(.WIDTH(32), .DEPTH(ORDER_SLOTS)) u_slot_ident (
        .clk(clk), .we(si_we), .waddr(si_wa), .wdata(si_wd), .raddr(si_ra), .rdata(si_rd));
    lobm_ram #(.WIDTH(32), .DEPTH(ORDER_SLOTS)) u_slot_qty (
        .clk(clk), .we(sq_we), .waddr(sq_wa), .wdata(sq_wd), .raddr(sq_ra), .rdata(sq_rd));

    // ---------------- registers ----------------
    lobm_pkg::state_t state_reg, state_next;
    logic          clr_busy_reg, clr_busy_next;
    logic [LW-1:0] clr_idx_reg, clr_idx_next;
    logic [HW-1:0] free_head_reg, free_head_next;
    logic [HW-1:0] never_used_reg, never_used_next;
    logic [PW-1:0] best_bid_reg, best_bid_next;
    logic [PW-1:0] best_ask_reg, best_ask_next;
    logic          out_valid_reg, out_valid_next;

    // item payload and working values
    logic          buy_reg, buy_next;
    logic [LW-1:0] price_reg, price_next;
    logic [31:0]   qty_reg, qty_next, ident_reg, ident_next;
    logic [SW-1:0] slot_reg, slot_next_v;
    logic [HW-1:0] bs_reg, bs_next, as_reg, as_next;
    logic [31:0]   bq_reg, bq_next;
    logic [31:0]   bid_id_reg, bid_id_next, ask_id_reg, ask_id_next;
    logic [HW-1:0] bnext_reg, bnext_next;
    lobm_pkg::kind_t   kind_reg, kind_next;
    lobm_pkg::status_t status_reg, status_next;
    logic [31:0]   fill_reg, fill_next;

    logic crossed;
    assign crossed = (best_bid_reg != '0) && (best_ask_reg <= PW'(MAX_PRICE_LEVEL))
                     && (best_bid_reg >= best_ask_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lobm_pkg::S_IDLE;
            clr_busy_reg   <= 1'b1;
            clr_idx_reg    <= '0;
            free_head_reg  <= NIL;
            never_used_reg <= '0;
            best_bid_reg   <= '0;
            best_ask_reg   <= NO_ASK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_busy_reg   <= clr_busy_next;
            clr_idx_reg    <= clr_idx_next;
            free_head_reg  <= free_head_next;
            never_used_reg <= never_used_next;
            best_bid_reg   <= best_bid_next;
            best_ask_reg   <= best_ask_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buy_reg    <= buy_next;
        price_reg  <= price_next;
        qty_reg    <= qty_next;
        ident_reg  <= ident_next;
        slot_reg   <= slot_next_v;
        bs_reg     <= bs_next;
        as_reg     <= as_next;
        bq_reg     <= bq_next;
        bid_id_reg <= bid_id_next;
        ask_id_reg <= ask_id_next;
        bnext_reg  <= bnext_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        fill_reg   <= fill_next;
    end

    // ---------------- next state ----------------
    logic [HW-1:0] slot_pick;
    logic          has_slot;
    assign has_slot  = (free_head_reg != NIL) || (never_used_reg != NIL);
    assign slot_pick = (free_head_reg != NIL) ? free_head_reg : never_used_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lobm_pkg::S_IDLE:
            begin
                if (!clr_busy_reg && in_ch.valid)
                begin
                    if (in_ch.payload.mode == 1'b0)
                    begin
                        if (in_ch.payload.price == '0
                            || 32'(in_ch.payload.price) > 32'(MAX_PRICE_LEVEL) || !has_slot)
                            state_next = lobm_pkg::S_DONE;
                        else
                            state_next = lobm_pkg::S_ADD_RD;
                    end
                    else if (!crossed)
                        state_next = lobm_pkg::S_DONE;
                    else
                        state_next = lobm_pkg::S_M_WAITHEAD;
                end
            end
            lobm_pkg::S_ADD_RD:       state_next = lobm_pkg::S_ADD_WAIT;
            lobm_pkg::S_ADD_WAIT:     state_next = lobm_pkg::S_ADD_WR;
            lobm_pkg::S_ADD_WR:
                // a non-empty level still needs its old tail linked to the new slot
                state_next = ((buy_reg ? bh_rd : ah_rd) == NIL) ? lobm_pkg::S_DONE
                                                                : lobm_pkg::S_ADD_LINK;
            lobm_pkg::S_ADD_LINK:     state_next = lobm_pkg::S_DONE;
            lobm_pkg::S_M_RDHEAD:     state_next = lobm_pkg::S_M_WAITHEAD;
            lobm_pkg::S_M_WAITHEAD:
            begin
                if (bh_rd == NIL || ah_rd == NIL)
                    state_next = lobm_pkg::S_DONE;
                else
                    state_next = lobm_pkg::S_M_RDSLOT;
            end
            lobm_pkg::S_M_RDSLOT:     state_next = lobm_pkg::S_M_WAITSLOT;
            lobm_pkg::S_M_WAITSLOT:   state_next = lobm_pkg::S_M_DECIDE;
            lobm_pkg::S_M_DECIDE:
                state_next = (bq_reg < sq_rd) ? lobm_pkg::S_M_POP_BID
                                              : lobm_pkg::S_M_POP_ASK;
            lobm_pkg::S_M_POP_ASK:
                state_next = (sn_rd == NIL) ? lobm_pkg::S_M_SCAN_ASK_RD
                           : (kind_reg == lobm_pkg::K_EQUAL) ? lobm_pkg::S_M_POP_BID
                                                             : lobm_pkg::S_DONE;
            lobm_pkg::S_M_SCAN_ASK_RD:   state_next = lobm_pkg::S_M_SCAN_ASK_CHK;
            lobm_pkg::S_M_SCAN_ASK_CHK:
            begin
                if (best_ask_reg > PW'(MAX_PRICE_LEVEL) || ah_rd != NIL)
                    state_next = (kind_reg == lobm_pkg::K_EQUAL) ? lobm_pkg::S_M_POP_BID
                                                                 : lobm_pkg::S_DONE;
                else
                    state_next = lobm_pkg::S_M_SCAN_ASK_RD;
            end
            lobm_pkg::S_M_POP_BID:
                state_next = (bnext_reg == NIL) ? lobm_pkg::S_M_SCAN_BID_RD
                                                : lobm_pkg::S_DONE;
            lobm_pkg::S_M_SCAN_BID_RD:   state_next = lobm_pkg::S_M_SCAN_BID_CHK;
            lobm_pkg::S_M_SCAN_BID_CHK:
            begin
                if (best_bid_reg == '0 || bh_rd != NIL)
                    state_next = lobm_pkg::S_DONE;
                else
                    state_next = lobm_pkg::S_M_SCAN_BID_RD;
            end
            lobm_pkg::S_DONE:
                if (!out_valid_reg || out_ch.ready)
                    state_next = lobm_pkg::S_IDLE;
            default: state_next = lobm_pkg::S_IDLE;
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb
    begin
        clr_busy_next   = clr_busy_reg;
        clr_idx_next    = clr_idx_reg;
        free_head_next  = free_head_reg;
        never_used_next = never_used_reg;
        best_bid_next   = best_bid_reg;
        best_ask_next   = best_ask_reg;
        out_valid_next  = out_valid_reg;
        buy_next    = buy_reg;
        price_next  = price_reg;
        qty_next    = qty_reg;
        ident_next  = ident_reg;
        slot_next_v = slot_reg;
        bs_next     = bs_reg;
        as_next     = as_reg;
        bq_next     = bq_reg;
        bid_id_next = bid_id_reg;
        ask_id_next = ask_id_reg;
        bnext_next  = bnext_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        fill_next   = fill_reg;

        bh_we = 1'b0; bh_wa = price_reg; bh_wd = NIL; bh_ra = price_reg;
        ah_we = 1'b0; ah_wa = price_reg; ah_wd = NIL; ah_ra = price_reg;
        bt_we = 1'b0; bt_wa = price_reg; bt_wd = slot_reg; bt_ra = price_reg;
        at_we = 1'b0; at_wa = price_reg; at_wd = slot_reg; at_ra = price_reg;
        sn_we = 1'b0; sn_wa = slot_reg; sn_wd = NIL; sn_ra = slot_reg;
        si_we = 1'b0; si_wa = slot_reg; si_wd = ident_reg; si_ra = slot_reg;
        sq_we = 1'b0; sq_wa = slot_reg; sq_wd = qty_reg; sq_ra = slot_reg;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        // post-reset sweep of the level heads
        if (clr_busy_reg)
        begin
            bh_we = 1'b1; bh_wa = clr_idx_reg; bh_wd = NIL;
            ah_we = 1'b1; ah_wa = clr_idx_reg; ah_wd = NIL;
            clr_idx_next = clr_idx_reg + 1'b1;
            if (32'(clr_idx_reg) == 32'(MAX_PRICE_LEVEL))
                clr_busy_next = 1'b0;
        end

        case (state_reg)
            lobm_pkg::S_IDLE:
            begin
                buy_next    = in_ch.payload.buy_not_sell;
                price_next  = LW'(in_ch.payload.price);
                qty_next    = in_ch.payload.quantity;
                ident_next  = in_ch.payload.order_ident;
                bid_id_next = '0;
                ask_id_next = '0;
                fill_next   = '0;
                if (in_ch.payload.mode)
                    status_next = lobm_pkg::ST_NO_CROSS;
                else
                    status_next = lobm_pkg::ST_REJECTED;
                // match steps read the best heads right away
                bh_ra = best_bid_reg[LW-1:0];
                ah_ra = best_ask_reg[LW-1:0];
                // free list pop needs the next link of the free head
                sn_ra = free_head_reg[SW-1:0];
            end
            lobm_pkg::S_ADD_RD:
            begin
                slot_next_v = slot_pick[SW-1:0];
                if (free_head_reg != NIL)
                    free_head_next = sn_rd;
                else
                    never_used_next = never_used_reg + 1'b1;
                bh_ra = price_reg; ah_ra = price_reg; bt_ra = price_reg; at_ra = price_reg;
            end
            lobm_pkg::S_ADD_WAIT:
            begin
                bh_ra = price_reg; ah_ra = price_reg;
            end
            lobm_pkg::S_ADD_WR:
            begin
                si_we = 1'b1; sq_we = 1'b1; sn_we = 1'b1; sn_wd = NIL;
                if (buy_reg)
                begin
                    bt_we = 1'b1;
                    if (bh_rd == NIL)
                    begin
                        bh_we = 1'b1; bh_wd = {1'b0, slot_reg};
                    end
                    if (PW'(price_reg) > best_bid_reg)
                        best_bid_next = PW'(price_reg);
                end
                else
                begin
                    at_we = 1'b1;
                    if (ah_rd == NIL)
                    begin
                        ah_we = 1'b1; ah_wd = {1'b0, slot_reg};
                    end
                    if (PW'(price_reg) < best_ask_reg)
                        best_ask_next = PW'(price_reg);
                end
                status_next = lobm_pkg::ST_ADDED;
            end
            lobm_pkg::S_ADD_LINK:
            begin
                // tail read still shows the level's old tail
                sn_we = 1'b1;
                sn_wa = buy_reg ? bt_rd : at_rd;
                sn_wd = {1'b0, slot_reg};
            end
            lobm_pkg::S_M_WAITHEAD:
            begin
                bs_next = bh_rd;
                as_next = ah_rd;
            end
            lobm_pkg::S_M_RDSLOT:
            begin
                sq_ra = bs_reg[SW-1:0]; si_ra = bs_reg[SW-1:0]; sn_ra = bs_reg[SW-1:0];
            end
            lobm_pkg::S_M_WAITSLOT:
            begin
                bq_next     = sq_rd;
                bid_id_next = si_rd;
                bnext_next  = sn_rd;
                sq_ra = as_reg[SW-1:0]; si_ra = as_reg[SW-1:0]; sn_ra = as_reg[SW-1:0];
            end
            lobm_pkg::S_M_DECIDE:
            begin
                ask_id_next = si_rd;
                status_next = lobm_pkg::ST_TRADE;
                sn_ra = as_reg[SW-1:0];
                if (bq_reg > sq_rd)
                begin
                    kind_next = lobm_pkg::K_ASK_SMALLER;
                    fill_next = sq_rd;
                    sq_we = 1'b1; sq_wa = bs_reg[SW-1:0]; sq_wd = bq_reg - sq_rd;
                end
                else if (bq_reg < sq_rd)
                begin
                    kind_next = lobm_pkg::K_BID_SMALLER;
                    fill_next = bq_reg;
                    sq_we = 1'b1; sq_wa = as_reg[SW-1:0]; sq_wd = sq_rd - bq_reg;
                end
                else
                begin
                    kind_next = lobm_pkg::K_EQUAL;
                    fill_next = bq_reg;
                end
            end
            lobm_pkg::S_M_POP_ASK:
            begin
                // sn_rd holds the link of the ask front slot
                ah_we = 1'b1; ah_wa = best_ask_reg[LW-1:0]; ah_wd = sn_rd;
                sn_we = 1'b1; sn_wa = as_reg[SW-1:0]; sn_wd = free_head_reg;
                free_head_next = as_reg;
                if (sn_rd == NIL)
                    best_ask_next = best_ask_reg + 1'b1;
            end
            lobm_pkg::S_M_SCAN_ASK_RD:
            begin
                ah_ra = best_ask_reg[LW-1:0];
            end
            lobm_pkg::S_M_SCAN_ASK_CHK:
            begin
                if (!(best_ask_reg > PW'(MAX_PRICE_LEVEL) || ah_rd != NIL))
                    best_ask_next = best_ask_reg + 1'b1;
            end
            lobm_pkg::S_M_POP_BID:
            begin
                bh_we = 1'b1; bh_wa = best_bid_reg[LW-1:0]; bh_wd = bnext_reg;
                sn_we = 1'b1; sn_wa = bs_reg[SW-1:0]; sn_wd = free_head_reg;
                free_head_next = bs_reg;
                if (bnext_reg == NIL)
                    best_bid_next = best_bid_reg - 1'b1;
            end
            lobm_pkg::S_M_SCAN_BID_RD:
            begin
                bh_ra = best_bid_reg[LW-1:0];
            end
            lobm_pkg::S_M_SCAN_BID_CHK:
            begin
                if (!(best_bid_reg == '0 || bh_rd != NIL))
                    best_bid_next = best_bid_reg - 1'b1;
            end
            lobm_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                    out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    lobm_pkg::result_t res_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == lobm_pkg::S_DONE && (!out_valid_reg || out_ch.ready))
        begin
            res_reg.status        <= status_reg;
            res_reg.bid_ident     <= bid_id_reg;
            res_reg.ask_ident     <= ask_id_reg;
            res_reg.fill_quantity <= fill_reg;
            res_reg.still_crossed <= crossed;
        end
    end

    assign in_ch.ready                  = (state_reg == lobm_pkg::S_IDLE) && !clr_busy_reg;
    assign out_ch.valid                 = out_valid_reg;
    assign out_ch.payload.status        = res_reg.status;
    assign out_ch.payload.bid_ident     = res_reg.bid_ident;
    assign out_ch.payload.ask_ident     = res_reg.ask_ident;
    assign out_ch.payload.fill_quantity = res_reg.fill_quantity;
    assign out_ch.payload.still_crossed = res_reg.still_crossed;

    // ---------------- assertions ----------------
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !in_ch.ready)
        else $error("item accepted during head sweep");

    a_bid_range: assert property (@(posedge clk) disable iff (!rst_n)
        best_bid_reg <= PW'(MAX_PRICE_LEVEL))
        else $error("best bid out of range");

    a_ask_range: assert property (@(posedge clk) disable iff (!rst_n)
        best_ask_reg != '0)
        else $error("best ask at zero");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("second item accepted while busy");
endmodule
`default_nettype wire
